// File: hdl/ephr_pkg.sv
package ephr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 32;
    localparam int THR_BITS    = 16;
    localparam int TPM_BITS    = 32;
    localparam int COUNT_BITS  = 16;
    localparam int RATE_BITS   = 16;
    localparam int SCALE_BITS  = 4;   // rate is in 1/16 bpm
    localparam int MCAND_BITS  = TPM_BITS + SCALE_BITS;
    localparam int NUM_BITS    = MCAND_BITS + COUNT_BITS;
    localparam int STEP_BITS   = $clog2(COUNT_BITS);
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICKS     = 1'b1;

    localparam logic [TPM_BITS-1:0]   TPM_RESET = 32'd60000;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [RATE_BITS-1:0]  RATE_MAX  = {RATE_BITS{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic        [TIME_BITS-1:0]   sample_time;
        logic                          record_start;
    } t_sample;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered_value;
        logic                          peak_found;
        logic        [TIME_BITS-1:0]   peak_time;
        logic        [RATE_BITS-1:0]   heart_rate;
        logic                          rate_valid;
    } t_result;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered;
        logic                          found;
        logic        [TIME_BITS-1:0]   ptime;
    } t_peak_out;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [TIME_BITS-1:0]  first;
        logic [TIME_BITS-1:0]  last;
    } t_peak_stats;

    typedef enum logic [1:0] {
        T_IDLE,
        T_RATE,
        T_HOLD
    } t_top_state;

    typedef enum logic [2:0] {
        R_IDLE,
        R_MUL,
        R_CHK,
        R_DIV,
        R_DONE
    } t_rate_state;

endpackage

// File: hdl/ecg_peak_heart_rate_core.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_data   (t_sample)
// result    out        o_out_valid / i_out_ready  o_out_data  (t_result)
// config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_wdata
//
// One transfer in, one transfer out per sample. The filter and peak test
// finish in the cycle of the input transfer; the rate unit then runs a
// bit-serial multiply, one overflow compare and a restoring divide. On rate
// overflow the divide is skipped and the rate saturates to RATE_MAX; with
// fewer than two peaks or no positive span both are skipped, rate_valid low.
// Reset is synchronous, active low: config returns to threshold 0 and
// 60000 ticks/minute, filter and peak history clear. A stalled result sits
// in the output register while the next sample is taken in; the core only
// holds o_in_ready low while the rate unit is busy or its result is blocked.
module ecg_peak_heart_rate_core
    import ephr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_sample                   i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_result                   o_out_data,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata
);

    t_top_state r_state, n_state;

    logic signed [THR_BITS-1:0] r_threshold;
    logic        [TPM_BITS-1:0] r_tpm;
    logic                       r_kick;     // starts rate unit after stats settle
    logic                       r_out_valid;
    t_result                    r_out;

    logic                  in_fire;
    logic                  slot_free;
    logic                  load_out;
    t_peak_out             peak;
    t_peak_stats           stats;
    logic                  rate_done;
    logic [RATE_BITS-1:0]  rate;
    logic                  rate_ok;

    // config registers; the user must write them only while idle, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_tpm       <= TPM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata[THR_BITS-1:0];
                CFG_TICKS:     r_tpm       <= i_cfg_wdata[TPM_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    ephr_peak u_peak (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_sample    (i_in_data),
        .i_threshold (r_threshold),
        .o_peak      (peak),
        .o_stats     (stats)
    );

    ephr_rate u_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_stats (stats),
        .i_tpm   (r_tpm),
        .o_done  (rate_done),
        .o_rate  (rate),
        .o_valid (rate_ok)
    );

    // sequencer: idle -> rate running -> (hold while output is blocked)
    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (i_in_valid) begin
                    n_state = T_RATE;
                end
            end
            T_RATE: begin
                if (rate_done) begin
                    n_state = slot_free ? T_IDLE : T_HOLD;
                end
            end
            T_HOLD: begin
                if (slot_free) begin
                    n_state = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_comb begin
        slot_free  = !r_out_valid || i_out_ready;
        o_in_ready = (r_state == T_IDLE);
        in_fire    = o_in_ready && i_in_valid;
        load_out   = ((r_state == T_RATE) && rate_done && slot_free)
                   || ((r_state == T_HOLD) && slot_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_kick      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kick  <= in_fire;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.filtered_value <= peak.filtered;
            r_out.peak_found     <= peak.found;
            r_out.peak_time      <= peak.ptime;
            r_out.heart_rate     <= rate;
            r_out.rate_valid     <= rate_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/ephr_peak.sv
module ephr_peak
    import ephr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  t_sample                     i_sample,
    input  logic signed [THR_BITS-1:0]  i_threshold,
    output t_peak_out                   o_peak,
    output t_peak_stats                 o_stats
);

    logic signed [SAMPLE_BITS-1:0] r_prev, r_mid;
    logic        [TIME_BITS-1:0]   r_mid_time;
    logic        [1:0]             r_seen;
    t_peak_stats                   r_stats;
    t_peak_out                     r_out;

    logic        [1:0]             seen_eff;
    t_peak_stats                   stats_eff;
    logic signed [SAMPLE_BITS:0]   sum;
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          found;
    t_peak_stats                   n_stats;

    always_comb begin
        seen_eff  = i_sample.record_start ? 2'd0 : r_seen;
        stats_eff = i_sample.record_start ? '0 : r_stats;
        // floor((x + y_prev) / 2) via arithmetic shift
        sum = {i_sample.sample_value[SAMPLE_BITS-1], i_sample.sample_value}
            + {r_mid[SAMPLE_BITS-1], r_mid};
        if (seen_eff == 2'd0) begin
            y = i_sample.sample_value;
        end else begin
            y = sum[SAMPLE_BITS:1];
        end
        found = (seen_eff == 2'd2) && (r_mid > r_prev) && (r_mid > y)
              && (r_mid > i_threshold);
        n_stats = stats_eff;
        if (found) begin
            if (stats_eff.count == '0) begin
                n_stats.first = r_mid_time;
            end
            n_stats.last = r_mid_time;
            if (stats_eff.count != COUNT_MAX) begin
                n_stats.count = stats_eff.count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_mid      <= '0;
            r_mid_time <= '0;
            r_seen     <= 2'd0;
            r_stats    <= '0;
            r_out      <= '0;
        end else if (i_fire) begin
            r_prev     <= r_mid;
            r_mid      <= y;
            r_mid_time <= i_sample.sample_time;
            r_seen     <= (seen_eff == 2'd2) ? 2'd2 : seen_eff + 2'd1;
            r_stats    <= n_stats;
            r_out.filtered <= y;
            r_out.found    <= found;
            r_out.ptime    <= found ? r_mid_time : '0;
        end
    end

    assign o_peak  = r_out;
    assign o_stats = r_stats;

endmodule

// File: hdl/ephr_rate.sv
module ephr_rate
    import ephr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_peak_stats           i_stats,
    input  logic [TPM_BITS-1:0]   i_tpm,
    output logic                  o_done,
    output logic [RATE_BITS-1:0]  o_rate,
    output logic                  o_valid
);

    t_rate_state r_state, n_state;

    logic [NUM_BITS-1:0]   r_acc;
    logic [MCAND_BITS-1:0] r_mcand;
    logic [COUNT_BITS-1:0] r_mult;
    logic [TIME_BITS-1:0]  r_span;
    logic [TIME_BITS-1:0]  r_rem;
    logic [RATE_BITS-1:0]  r_lo;
    logic [RATE_BITS-1:0]  r_q;
    logic [STEP_BITS-1:0]  r_cnt;
    logic                  r_ok;

    logic                  ok_in;
    logic                  last_step;
    logic [NUM_BITS-1:0]   acc_next;
    logic [TIME_BITS:0]    trial;
    logic                  q_bit;
    logic                  ovf;

    always_comb begin
        ok_in     = (i_stats.count >= COUNT_BITS'(2)) && (i_stats.last > i_stats.first);
        last_step = (r_cnt == {STEP_BITS{1'b1}});
        // MSB-first shift-add, one multiplier bit per cycle
        acc_next  = {r_acc[NUM_BITS-2:0], 1'b0}
                  + (r_mult[COUNT_BITS-1] ? NUM_BITS'(r_mcand) : '0);
        // restoring divide, one quotient bit per cycle
        trial     = {r_rem, r_lo[RATE_BITS-1]};
        q_bit     = (trial >= {1'b0, r_span});
        ovf       = (r_acc[NUM_BITS-1:RATE_BITS]
                     >= (NUM_BITS-RATE_BITS)'(r_span));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            R_IDLE: begin
                if (i_start) begin
                    n_state = ok_in ? R_MUL : R_DONE;
                end
            end
            R_MUL: begin
                if (last_step) begin
                    n_state = R_CHK;
                end
            end
            R_CHK: begin
                n_state = ovf ? R_DONE : R_DIV;
            end
            R_DIV: begin
                if (last_step) begin
                    n_state = R_DONE;
                end
            end
            R_DONE: begin
                n_state = R_IDLE;
            end
            default: begin
                n_state = R_IDLE;
            end
        endcase
    end

    always_comb begin
        o_done = (r_state == R_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_cnt   <= '0;
            r_ok    <= 1'b0;
            r_q     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                R_IDLE: begin
                    if (i_start) begin
                        r_ok    <= ok_in;
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_acc   <= '0;
                        r_mcand <= {i_tpm, {SCALE_BITS{1'b0}}};
                        r_mult  <= i_stats.count - 1'b1;
                        r_span  <= i_stats.last - i_stats.first;
                    end
                end
                R_MUL: begin
                    r_acc  <= acc_next;
                    r_mult <= {r_mult[COUNT_BITS-2:0], 1'b0};
                    r_cnt  <= r_cnt + 1'b1;
                end
                R_CHK: begin
                    r_cnt <= '0;
                    if (ovf) begin
                        r_q <= RATE_MAX;
                    end else begin
                        // high part is below the span, so it fits the remainder
                        r_rem <= r_acc[TIME_BITS+RATE_BITS-1:RATE_BITS];
                        r_lo  <= r_acc[RATE_BITS-1:0];
                    end
                end
                R_DIV: begin
                    r_rem <= q_bit ? TIME_BITS'(trial - {1'b0, r_span})
                                   : trial[TIME_BITS-1:0];
                    r_lo  <= {r_lo[RATE_BITS-2:0], 1'b0};
                    r_q   <= {r_q[RATE_BITS-2:0], q_bit};
                    r_cnt <= r_cnt + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rate  = r_q;
    assign o_valid = r_ok;

endmodule
